### hw/rtl/efd_pkg.sv
package efd_pkg;

   localparam int ByteW           = 8;
   localparam int LengthW         = 9;
   localparam int StatusW         = 3;
   localparam int CsrIndexW       = 3;
   localparam int DefaultMaxPayload = 256;

   localparam logic [ByteW-1:0] StartMarkerReset   = 8'd253;
   localparam logic [ByteW-1:0] AddressMarkerReset = 8'd254;
   localparam logic [ByteW-1:0] EndMarkerReset     = 8'd255;
   localparam logic [ByteW-1:0] EscapeMarkerReset  = 8'd252;

   typedef enum logic [CsrIndexW-1:0] {
      REG_START_MARKER   = 3'd0,
      REG_ADDRESS_MARKER = 3'd1,
      REG_END_MARKER     = 3'd2,
      REG_ESCAPE_MARKER  = 3'd3,
      REG_START_OPTIONAL = 3'd4
   } reg_index_type;

   typedef enum logic [StatusW-1:0] {
      STATUS_OK         = 3'd0,
      STATUS_TIMEOUT    = 3'd1,
      STATUS_ESC_RANGE  = 3'd2,
      STATUS_BAD_START  = 3'd3,
      STATUS_BAD_END    = 3'd4,
      STATUS_OVERFLOW   = 3'd5
   } status_type;

   typedef struct packed {
      logic [ByteW-1:0] start_marker;
      logic [ByteW-1:0] address_marker;
      logic [ByteW-1:0] end_marker;
      logic [ByteW-1:0] escape_marker;
      logic             start_optional;
      logic             start_optional_wr;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic               frame_done;
      logic [ByteW-1:0]   payload_byte;
      status_type         status;
      logic [LengthW-1:0] frame_length;
      logic [ByteW-1:0]   frame_address;
   } result_type;

endpackage

### hw/rtl/efd_if.sv
interface efd_req_if;
   logic                      valid;
   logic                      ready;
   logic                      func;
   logic [efd_pkg::ByteW-1:0] rx_byte;

   modport source (output valid, output func, output rx_byte, input ready);
   modport sink (input valid, input func, input rx_byte, output ready);
endinterface

interface efd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        frame_done;
   logic [efd_pkg::ByteW-1:0]   payload_byte;
   logic [efd_pkg::StatusW-1:0] status;
   logic [efd_pkg::LengthW-1:0] frame_length;
   logic [efd_pkg::ByteW-1:0]   frame_address;

   modport source (output valid, output frame_done, output payload_byte, output status,
                   output frame_length, output frame_address, input ready);
   modport sink (input valid, input frame_done, input payload_byte, input status,
                 input frame_length, input frame_address, output ready);
endinterface

interface efd_csr_if;
   logic                          valid;
   logic                          ready;
   logic [efd_pkg::CsrIndexW-1:0] index;
   logic [efd_pkg::ByteW-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/efd_csr.sv
module efd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [efd_pkg::CsrIndexW-1:0] wr_index,
   input  logic [efd_pkg::ByteW-1:0]     wr_data,
   output efd_pkg::cfg_type              cfg
);
   import efd_pkg::*;

   logic [ByteW-1:0] start_marker_ff;
   logic [ByteW-1:0] address_marker_ff;
   logic [ByteW-1:0] end_marker_ff;
   logic [ByteW-1:0] escape_marker_ff;
   logic             start_optional_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff   <= StartMarkerReset;
         address_marker_ff <= AddressMarkerReset;
         end_marker_ff     <= EndMarkerReset;
         escape_marker_ff  <= EscapeMarkerReset;
         start_optional_ff <= 1'b0;
      end else if (wr_en) begin
         case (reg_index_type'(wr_index))
            REG_START_MARKER: begin
               start_marker_ff <= wr_data;
            end
            REG_ADDRESS_MARKER: begin
               address_marker_ff <= wr_data;
            end
            REG_END_MARKER: begin
               end_marker_ff <= wr_data;
            end
            REG_ESCAPE_MARKER: begin
               escape_marker_ff <= wr_data;
            end
            REG_START_OPTIONAL: begin
               start_optional_ff <= wr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.start_marker      = start_marker_ff;
      cfg.address_marker    = address_marker_ff;
      cfg.end_marker        = end_marker_ff;
      cfg.escape_marker     = escape_marker_ff;
      // new value seen at once so the frame state can follow
      cfg.start_optional    = start_optional_ff;
      cfg.start_optional_wr = wr_en && (wr_index == REG_START_OPTIONAL);
      if (cfg.start_optional_wr) begin
         cfg.start_optional = wr_data[0];
      end
   end

endmodule

### hw/rtl/efd_core.sv
module efd_core #(
   parameter int MaxPayload = efd_pkg::DefaultMaxPayload
) (
   input  logic                      clock,
   input  logic                      reset,
   input  efd_pkg::cfg_type          cfg,
   input  logic                      step,
   input  logic                      func,
   input  logic [efd_pkg::ByteW-1:0] rx_byte,
   output efd_pkg::result_type       result
);
   import efd_pkg::*;

   localparam int CntW = $clog2(MaxPayload + 1);

   logic            escape_pending_ff, escape_pending_in;
   logic            address_next_ff, address_next_in;
   logic            awaiting_start_ff, awaiting_start_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [ByteW-1:0] address_ff, address_in;

   logic             do_finish;
   status_type       finish_code;
   logic             do_accept;
   logic [ByteW-1:0] accept_value;
   logic [ByteW:0]   restored;
   logic             full;

   always_comb begin
      escape_pending_in = escape_pending_ff;
      address_next_in   = address_next_ff;
      awaiting_start_in = awaiting_start_ff;
      count_in          = count_ff;
      address_in        = address_ff;
      do_finish         = 1'b0;
      finish_code       = STATUS_OK;
      do_accept         = 1'b0;
      accept_value      = rx_byte;
      restored          = {1'b0, rx_byte} + {1'b0, cfg.escape_marker};
      full              = (count_ff == CntW'(MaxPayload));

      if (func) begin
         do_finish   = 1'b1;
         finish_code = STATUS_TIMEOUT;
      end else if (escape_pending_ff) begin
         if (restored[ByteW]) begin
            do_finish   = 1'b1;
            finish_code = STATUS_ESC_RANGE;
         end else begin
            escape_pending_in = 1'b0;
            do_accept         = 1'b1;
            accept_value      = restored[ByteW-1:0];
         end
      end else if (address_next_ff) begin
         address_in      = rx_byte;
         address_next_in = 1'b0;
      end else if (rx_byte == cfg.start_marker) begin
         if (!awaiting_start_ff) begin
            do_finish   = 1'b1;
            finish_code = STATUS_BAD_START;
         end else begin
            awaiting_start_in = 1'b0;
         end
      end else if (rx_byte == cfg.address_marker) begin
         address_next_in = 1'b1;
      end else if (rx_byte == cfg.end_marker) begin
         do_finish   = 1'b1;
         finish_code = awaiting_start_ff ? STATUS_BAD_END : STATUS_OK;
      end else if (rx_byte == cfg.escape_marker) begin
         escape_pending_in = 1'b1;
      end else begin
         do_accept = 1'b1;
      end

      // payload past the limit drops the byte and closes the frame
      if (do_accept && full) begin
         do_accept   = 1'b0;
         do_finish   = 1'b1;
         finish_code = STATUS_OVERFLOW;
      end

      if (do_accept) begin
         count_in = count_ff + CntW'(1);
      end

      result.valid         = do_accept || do_finish;
      result.frame_done    = do_finish;
      result.payload_byte  = do_finish ? '0 : accept_value;
      result.status        = do_finish ? finish_code : STATUS_OK;
      result.frame_length  = do_finish ? LengthW'(count_ff) : LengthW'(count_in);
      result.frame_address = address_ff;

      if (do_finish) begin
         escape_pending_in = 1'b0;
         address_next_in   = 1'b0;
         awaiting_start_in = !cfg.start_optional;
         count_in          = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_pending_ff <= 1'b0;
         address_next_ff   <= 1'b0;
         awaiting_start_ff <= 1'b1;
         count_ff          <= '0;
         address_ff        <= '0;
      end else if (step) begin
         escape_pending_ff <= escape_pending_in;
         address_next_ff   <= address_next_in;
         awaiting_start_ff <= awaiting_start_in;
         count_ff          <= count_in;
         address_ff        <= address_in;
      end else if (cfg.start_optional_wr) begin
         awaiting_start_ff <= !cfg.start_optional;
      end
   end

endmodule

### hw/rtl/escaped_frame_decoder.sv
// Byte-stuffing frame decoder. Takes one received byte (or a timeout event) per cycle
// unless rsp stalls, and returns at most one result per input: a payload byte as soon as it
// is decoded, or a status result that closes the frame. An input transfer passes through an
// input register and the decode logic into a result register, from which it is presented;
// with rsp ready held high a new transfer is taken every cycle, and while a finished result
// waits the input register can still take one more transfer.
// Marker registers and start_optional are written through the csr channel; the user must
// write them only while idle, the block itself does not enforce this.
module escaped_frame_decoder #(
   parameter int MaxPayload = efd_pkg::DefaultMaxPayload
) (
   input logic        clock,
   input logic        reset,
   efd_req_if.sink    req_ch,
   efd_rsp_if.source  rsp_ch,
   efd_csr_if.sink    csr_ch
);
   import efd_pkg::*;

   cfg_type    cfg;
   result_type result;

   logic             in_valid_ff;
   logic             in_func_ff;
   logic [ByteW-1:0] in_byte_ff;
   logic             out_valid_ff;
   logic             out_done_ff;
   logic [ByteW-1:0] out_byte_ff;
   logic [StatusW-1:0] out_status_ff;
   logic [LengthW-1:0] out_length_ff;
   logic [ByteW-1:0]   out_address_ff;

   logic advance;
   logic step;
   logic take;

   assign advance = !out_valid_ff || rsp_ch.ready;
   assign step    = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;
   assign take    = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   efd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   efd_core #(
      .MaxPayload (MaxPayload)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step    (step),
      .func    (in_func_ff),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
      if (take) begin
         in_func_ff <= req_ch.func;
         in_byte_ff <= req_ch.rx_byte;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= step && result.valid;
      end
      if (step && result.valid) begin
         out_done_ff    <= result.frame_done;
         out_byte_ff    <= result.payload_byte;
         out_status_ff  <= result.status;
         out_length_ff  <= result.frame_length;
         out_address_ff <= result.frame_address;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.frame_done    = out_done_ff;
   assign rsp_ch.payload_byte  = out_byte_ff;
   assign rsp_ch.status        = out_status_ff;
   assign rsp_ch.frame_length  = out_length_ff;
   assign rsp_ch.frame_address = out_address_ff;

endmodule

### tb/escaped_frame_decoder_tb.sv
`timescale 1ns / 1ps

module escaped_frame_decoder_tb;
   import efd_pkg::*;

   localparam int ByteTop = (1 << ByteW) - 1;
   localparam int CycleLimit = 1000000;

   typedef struct packed {
      logic               frame_done;
      logic [ByteW-1:0]   payload_byte;
      status_type         status;
      logic [LengthW-1:0] frame_length;
      logic [ByteW-1:0]   frame_address;
   } frame_result_type;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   class frame_scoreboard;
      logic [ByteW-1:0] start_mk;
      logic [ByteW-1:0] addr_mk;
      logic [ByteW-1:0] end_mk;
      logic [ByteW-1:0] esc_mk;
      logic             start_opt;
      bit               esc_pending;
      bit               addr_next;
      bit               await_start;
      int unsigned      payload_count;
      logic [ByteW-1:0] addr_q;
      frame_result_type expected_q[$];
      int               errors;

      function void clear_frame();
         esc_pending = 1'b0;
         addr_next = 1'b0;
         await_start = !start_opt;
         payload_count = 0;
      endfunction

      function void reset_state();
         start_mk = StartMarkerReset;
         addr_mk = AddressMarkerReset;
         end_mk = EndMarkerReset;
         esc_mk = EscapeMarkerReset;
         start_opt = 1'b0;
         addr_q = '0;
         clear_frame();
      endfunction

      function void write_reg(logic [CsrIndexW-1:0] index, logic [ByteW-1:0] data);
         case (index)
            REG_START_MARKER: start_mk = data;
            REG_ADDRESS_MARKER: addr_mk = data;
            REG_END_MARKER: end_mk = data;
            REG_ESCAPE_MARKER: esc_mk = data;
            REG_START_OPTIONAL: begin
               start_opt = data[0];
               await_start = !start_opt;
            end
            default: ;
         endcase
      endfunction

      function void close_frame(status_type st);
         frame_result_type r;
         r.frame_done = 1'b1;
         r.payload_byte = '0;
         r.status = st;
         r.frame_length = LengthW'(payload_count);
         r.frame_address = addr_q;
         expected_q.push_back(r);
         clear_frame();
      endfunction

      function void take_payload(logic [ByteW-1:0] value);
         frame_result_type r;
         if (payload_count >= DefaultMaxPayload) begin
            close_frame(STATUS_OVERFLOW);
            return;
         end
         payload_count++;
         r.frame_done = 1'b0;
         r.payload_byte = value;
         r.status = STATUS_OK;
         r.frame_length = LengthW'(payload_count);
         r.frame_address = addr_q;
         expected_q.push_back(r);
      endfunction

      function void note_input(logic func, logic [ByteW-1:0] b);
         int restored;
         if (func) begin
            close_frame(STATUS_TIMEOUT);
            return;
         end
         if (esc_pending) begin
            restored = int'(b) + int'(esc_mk);
            if (restored > ByteTop) begin
               close_frame(STATUS_ESC_RANGE);
            end else begin
               esc_pending = 1'b0;
               take_payload(ByteW'(restored));
            end
         end else if (addr_next) begin
            addr_q = b;
            addr_next = 1'b0;
         end else if (b == start_mk) begin
            if (!await_start) close_frame(STATUS_BAD_START);
            else await_start = 1'b0;
         end else if (b == addr_mk) begin
            addr_next = 1'b1;
         end else if (b == end_mk) begin
            if (await_start) close_frame(STATUS_BAD_END);
            else close_frame(STATUS_OK);
         end else if (b == esc_mk) begin
            esc_pending = 1'b1;
         end else begin
            take_payload(b);
         end
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_result(frame_result_type got);
         frame_result_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result with nothing pending, done=%0d byte=%0h status=%0d",
                             got.frame_done, got.payload_byte, got.status));
            return;
         end
         want = expected_q.pop_front();
         if (got.frame_done !== want.frame_done)
            report($sformatf("frame_done exp %0d got %0d", want.frame_done, got.frame_done));
         if (got.payload_byte !== want.payload_byte)
            report($sformatf("payload_byte exp %0h got %0h", want.payload_byte, got.payload_byte));
         if (got.status !== want.status)
            report($sformatf("status exp %0d got %0d", want.status, got.status));
         if (got.frame_length !== want.frame_length)
            report($sformatf("frame_length exp %0d got %0d", want.frame_length, got.frame_length));
         if (got.frame_address !== want.frame_address)
            report($sformatf("frame_address exp %0h got %0h", want.frame_address,
                             got.frame_address));
      endtask
   endclass

   logic clock;
   logic reset;

   efd_req_if req_if();
   efd_rsp_if rsp_if();
   efd_csr_if csr_if();

   escaped_frame_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   frame_scoreboard sb = new;
   int unsigned cycle_count;
   int unsigned items_sent;
   int unsigned burst_left;
   stall_mode_type stall_mode;
   int unsigned stall_left;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin : rsp_stall
      logic rdy;
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 300);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         STALL_NONE: rdy = 1'b1;
         STALL_RANDOM: rdy = 1'($urandom_range(0, 1));
         STALL_HEAVY: rdy = ($urandom_range(0, 3) == 0);
         default: rdy = (stall_left % 5) != 2;
      endcase
      rsp_if.ready <= rdy;
   end

   always @(posedge clock) begin : monitor
      frame_result_type got;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.frame_done = rsp_if.frame_done;
            got.payload_byte = rsp_if.payload_byte;
            got.status = status_type'(rsp_if.status);
            got.frame_length = rsp_if.frame_length;
            got.frame_address = rsp_if.frame_address;
            sb.check_result(got);
         end
         if (csr_if.valid && csr_if.ready) sb.write_reg(csr_if.index, csr_if.data);
         if (req_if.valid && req_if.ready) sb.note_input(req_if.func, req_if.rx_byte);
      end
   end

   task automatic send_item(input logic func, input logic [ByteW-1:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, $urandom_range(1, 12));
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid <= 1'b1;
      req_if.func <= func;
      req_if.rx_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic write_csr(input logic [CsrIndexW-1:0] index, input logic [ByteW-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
   endtask

   // spare indexes are written too, they must leave the registers alone
   task automatic configure(input logic [ByteW-1:0] s, input logic [ByteW-1:0] a,
                            input logic [ByteW-1:0] e, input logic [ByteW-1:0] x,
                            input logic opt);
      int i;
      write_csr(REG_START_MARKER, s);
      write_csr(REG_ADDRESS_MARKER, a);
      write_csr(REG_END_MARKER, e);
      write_csr(REG_ESCAPE_MARKER, x);
      write_csr(REG_START_OPTIONAL, {7'($urandom_range(0, 127)), opt});
      for (i = REG_START_OPTIONAL + 1; i < (1 << CsrIndexW); i++)
         write_csr(CsrIndexW'(i), ByteW'($urandom));
      csr_if.valid <= 1'b0;
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [ByteW-1:0] pick_plain();
      logic [ByteW-1:0] b;
      b = ByteW'($urandom_range(0, ByteTop));
      while (b == sb.start_mk || b == sb.addr_mk || b == sb.end_mk || b == sb.esc_mk)
         b = ByteW'($urandom_range(0, ByteTop));
      return b;
   endfunction

   function automatic logic [ByteW-1:0] pick_any();
      case ($urandom_range(0, 7))
         0: return sb.start_mk;
         1: return sb.addr_mk;
         2: return sb.end_mk;
         3: return sb.esc_mk;
         default: return ByteW'($urandom_range(0, ByteTop));
      endcase
   endfunction

   task automatic send_payload();
      int esc;
      esc = int'(sb.esc_mk);
      if ($urandom_range(0, 5) == 0) begin
         send_item(1'b0, sb.esc_mk);
         if (esc > 0 && $urandom_range(0, 9) == 0)
            send_item(1'b0, ByteW'($urandom_range(ByteTop + 1 - esc, ByteTop)));
         else
            send_item(1'b0, ByteW'($urandom_range(0, ByteTop - esc)));
      end else begin
         send_item(1'b0, pick_plain());
      end
   endtask

   task automatic send_frame();
      int n;
      if ($urandom_range(0, 19) < 3) begin
         n = $urandom_range(1, 6);
         repeat (n) send_item($urandom_range(0, 15) == 0, pick_any());
         return;
      end
      if (!sb.start_opt || $urandom_range(0, 7) == 0) send_item(1'b0, sb.start_mk);
      if ($urandom_range(0, 1)) begin
         send_item(1'b0, sb.addr_mk);
         send_item(1'b0, ByteW'($urandom_range(0, ByteTop)));
      end
      n = $urandom_range(0, 12);
      repeat (n) send_payload();
      case ($urandom_range(0, 19))
         0, 1: send_item(1'b1, ByteW'($urandom_range(0, ByteTop)));
         2: send_item(1'b0, sb.start_mk);
         3: ;
         default: send_item(1'b0, sb.end_mk);
      endcase
   endtask

   // stops one short of the length limit, reaches exactly it, or runs past it into overflow
   task automatic send_long_frame();
      int n;
      if (!sb.start_opt) send_item(1'b0, sb.start_mk);
      n = DefaultMaxPayload - 1 + $urandom_range(0, 3);
      repeat (n) send_item(1'b0, pick_plain());
      send_item(1'b0, sb.end_mk);
   endtask

   task automatic run_random(input int unsigned count, input bit with_long);
      int unsigned target;
      target = items_sent + count;
      if (with_long) send_long_frame();
      while (items_sent < target) send_frame();
      settle();
   endtask

   task automatic run_directed();
      send_item(1'b1, 8'hFF);
      send_item(1'b0, EndMarkerReset);
      send_item(1'b0, 8'h00);
      send_item(1'b0, StartMarkerReset);
      send_item(1'b0, AddressMarkerReset);
      send_item(1'b0, 8'hA5);
      send_item(1'b0, 8'h5A);
      send_item(1'b0, 8'h7F);
      send_item(1'b0, EscapeMarkerReset);
      send_item(1'b0, 8'h03);
      send_item(1'b0, EscapeMarkerReset);
      send_item(1'b0, 8'h00);
      send_item(1'b0, AddressMarkerReset);
      send_item(1'b0, StartMarkerReset);
      send_item(1'b0, EndMarkerReset);
      send_item(1'b0, StartMarkerReset);
      send_item(1'b0, EscapeMarkerReset);
      send_item(1'b0, EscapeMarkerReset);
      send_item(1'b0, StartMarkerReset);
      send_item(1'b0, 8'h80);
      send_item(1'b0, StartMarkerReset);
      send_item(1'b0, StartMarkerReset);
      send_item(1'b0, 8'h01);
      send_item(1'b1, 8'h00);
      send_item(1'b0, StartMarkerReset);
      send_item(1'b0, EndMarkerReset);
      settle();
   endtask

   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.func <= 1'b0;
      req_if.rx_byte <= '0;
      csr_if.valid <= 1'b0;
      csr_if.index <= '0;
      csr_if.data <= '0;
      sb.reset_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_random(350, 1'b1);

      configure(8'h00, 8'hFF, 8'h80, 8'h01, 1'b1);
      run_random(350, 1'b0);

      // all markers coincide
      configure(8'h55, 8'h55, 8'h55, 8'h55, 1'b0);
      run_random(300, 1'b0);

      configure(8'hFF, 8'h00, 8'hFE, 8'hFF, 1'b1);
      run_random(350, 1'b1);

      configure(ByteW'($urandom_range(0, ByteTop)), ByteW'($urandom_range(0, ByteTop)),
                ByteW'($urandom_range(0, ByteTop)), 8'h00, 1'b0);
      run_random(350, 1'b0);

      configure(ByteW'($urandom_range(0, ByteTop)), ByteW'($urandom_range(0, ByteTop)),
                ByteW'($urandom_range(0, ByteTop)), ByteW'($urandom_range(0, ByteTop)),
                1'($urandom_range(0, 1)));
      run_random(350, 1'b1);

      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
